// ===== hdl/bgsf_pkg.sv =====
package bgsf_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 16;
    localparam int MODE_W   = 2;
    localparam int STATE_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // sliding window (power of two, 2 to 64)
    localparam int WINDOW_LENGTH = 8;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);

    // noise scramble working width and threshold
    localparam int NOISE_W = 18;
    localparam logic [NOISE_W-1:0] NOISE_THRESHOLD = NOISE_W'(500);

    // pwm compare shift
    localparam int PWM_SHIFT = 4;

    // run states
    localparam logic [STATE_W-1:0] ST_INIT   = 2'd0;
    localparam logic [STATE_W-1:0] ST_WAIT   = 2'd1;
    localparam logic [STATE_W-1:0] ST_LISTEN = 2'd2;
    localparam logic [STATE_W-1:0] ST_PAUSE  = 2'd3;

    // processing modes
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOISE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 1'd1;

    localparam logic [VALUE_W-1:0] MASK_RESET = 16'hFFFF;

endpackage

// ===== hdl/bgsf_in_if.sv =====
interface bgsf_in_if;
    logic                              valid;
    logic                              ready;
    logic                              button_level;
    logic                              digital_level;
    logic [bgsf_pkg::SAMPLE_W-1:0]     adc_sample;

    modport source (output valid, button_level, digital_level, adc_sample, input ready);
    modport sink   (input valid, button_level, digital_level, adc_sample, output ready);
endinterface

// ===== hdl/bgsf_out_if.sv =====
interface bgsf_out_if;
    logic                              valid;
    logic                              ready;
    logic [bgsf_pkg::STATE_W-1:0]      run_state;
    logic                              cli_enabled;
    logic                              sample_valid;
    logic                              digital_out;
    logic [bgsf_pkg::VALUE_W-1:0]      value_out;
    logic [bgsf_pkg::VALUE_W-1:0]      pwm_compare;

    modport source (output valid, run_state, cli_enabled, sample_valid, digital_out,
                    value_out, pwm_compare, input ready);
    modport sink   (input valid, run_state, cli_enabled, sample_valid, digital_out,
                    value_out, pwm_compare, output ready);
endinterface

// ===== hdl/bgsf_cell.sv =====
module bgsf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [bgsf_pkg::SAMPLE_W-1:0] i_din,
    output logic [bgsf_pkg::SAMPLE_W-1:0] o_dout
);

    logic [bgsf_pkg::SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_din;
        end
    end

    assign o_dout = r_data;

endmodule

// ===== hdl/bgsf_window.sv =====
module bgsf_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [bgsf_pkg::SAMPLE_W-1:0] i_sample,
    output logic [bgsf_pkg::SAMPLE_W-1:0] o_average
);

    localparam int W = bgsf_pkg::WINDOW_LENGTH;

    // chain link k+1 feeds cell k; cell 0 holds the oldest sample
    logic [bgsf_pkg::SAMPLE_W-1:0] w_link [W+1];
    logic [bgsf_pkg::SUM_W-1:0]    r_sum;
    logic [bgsf_pkg::SUM_W-1:0]    n_sum;

    assign w_link[W] = i_sample;

    for (genvar k = 0; k < W; k++) begin : g_cell
        bgsf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_din   (w_link[k+1]),
            .o_dout  (w_link[k])
        );
    end

    // running sum: new sample in, oldest out
    assign n_sum = r_sum + bgsf_pkg::SUM_W'(i_sample) - bgsf_pkg::SUM_W'(w_link[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_average = bgsf_pkg::SAMPLE_W'(n_sum / W);

endmodule

// ===== hdl/button_gated_sample_filter_top.sv =====
// a result appears on the output in the cycle after its request is accepted
// one request per cycle unless stalled; the window moves through a chain of sample cells
// with a running sum, so the average is ready in the same cycle as the request
// reset: synchronous active-low; run state to init, window and sum to zero,
// mode to raw, noise mask to all ones, output register empty
module button_gated_sample_filter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bgsf_in_if.sink                         i_req,
    bgsf_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bgsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgsf_pkg::CFG_W-1:0]      i_cfg_wdata
);

    // noise scramble, narrow because the sample is only twelve bits wide
    function automatic logic [bgsf_pkg::VALUE_W-1:0] noise_scramble(
        input logic [bgsf_pkg::SAMPLE_W-1:0] s,
        input logic [bgsf_pkg::VALUE_W-1:0]  mask
    );
        logic [bgsf_pkg::NOISE_W-1:0] v;
        v = bgsf_pkg::NOISE_W'(s);
        v = v ^ (v << s[1:0]);
        v = v + (v ^ (v >> 1));
        if (v < bgsf_pkg::NOISE_THRESHOLD) begin
            v = v + (v | bgsf_pkg::NOISE_W'(mask));
        end
        return v[bgsf_pkg::VALUE_W-1:0];
    endfunction

    // run state and configuration
    logic [bgsf_pkg::STATE_W-1:0] r_state;
    logic [bgsf_pkg::STATE_W-1:0] n_state;
    logic [bgsf_pkg::MODE_W-1:0]  r_mode;
    logic [bgsf_pkg::VALUE_W-1:0] r_mask;

    // output register
    logic                         r_out_valid;
    logic [bgsf_pkg::STATE_W-1:0] r_out_state;
    logic                         r_out_cli;
    logic                         r_out_svalid;
    logic                         r_out_dig;
    logic [bgsf_pkg::VALUE_W-1:0] r_out_value;
    logic [bgsf_pkg::VALUE_W-1:0] r_out_pwm;

    logic                          w_accept;
    logic                          w_pressed;
    logic                          w_cli;
    logic                          w_emit;
    logic                          w_shift;
    logic [bgsf_pkg::VALUE_W-1:0]  w_value;
    logic [bgsf_pkg::SAMPLE_W-1:0] w_average;

    // a new request may enter whenever the output slot is empty or empties this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_pressed   = !i_req.button_level;

    // next run state and per-request flags
    always_comb begin
        n_state = r_state;
        w_cli   = 1'b0;
        w_emit  = 1'b0;
        case (r_state)
            bgsf_pkg::ST_INIT: begin
                n_state = bgsf_pkg::ST_WAIT;
            end
            bgsf_pkg::ST_WAIT: begin
                w_cli = 1'b1;
                if (w_pressed) n_state = bgsf_pkg::ST_LISTEN;
            end
            bgsf_pkg::ST_LISTEN: begin
                if (w_pressed) begin
                    n_state = bgsf_pkg::ST_PAUSE;
                end else begin
                    w_emit = 1'b1;
                end
            end
            bgsf_pkg::ST_PAUSE: begin
                // cli stays on for the tick that resumes listening
                w_cli = 1'b1;
                if (w_pressed) n_state = bgsf_pkg::ST_LISTEN;
            end
            default: begin
                n_state = bgsf_pkg::ST_INIT;
            end
        endcase
    end

    // the window only moves on emitting ticks in averaging mode
    assign w_shift = w_accept && w_emit && (r_mode == bgsf_pkg::MODE_AVG);

    bgsf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (w_shift),
        .i_sample  (i_req.adc_sample),
        .o_average (w_average)
    );

    // value select; the unused mode code falls back to raw
    always_comb begin
        case (r_mode)
            bgsf_pkg::MODE_AVG:   w_value = bgsf_pkg::VALUE_W'(w_average);
            bgsf_pkg::MODE_NOISE: w_value = noise_scramble(i_req.adc_sample, r_mask);
            default:              w_value = bgsf_pkg::VALUE_W'(i_req.adc_sample);
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgsf_pkg::ST_INIT;
            r_mode      <= bgsf_pkg::MODE_RAW;
            r_mask      <= bgsf_pkg::MASK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            // init tick drops any mode written before it
            if (w_accept && (r_state == bgsf_pkg::ST_INIT)) begin
                r_mode <= bgsf_pkg::MODE_RAW;
            end else if (i_cfg_we && (i_cfg_idx == bgsf_pkg::REG_MODE)) begin
                r_mode <= i_cfg_wdata[bgsf_pkg::MODE_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == bgsf_pkg::REG_MASK)) begin
                r_mask <= i_cfg_wdata[bgsf_pkg::VALUE_W-1:0];
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, zeroed when no sample message goes out
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_state  <= n_state;
            r_out_cli    <= w_cli;
            r_out_svalid <= w_emit;
            r_out_dig    <= w_emit && i_req.digital_level;
            r_out_value  <= w_emit ? w_value : '0;
            r_out_pwm    <= w_emit ? {i_req.adc_sample, bgsf_pkg::PWM_SHIFT'(0)} : '0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.run_state    = r_out_state;
    assign o_rsp.cli_enabled  = r_out_cli;
    assign o_rsp.sample_valid = r_out_svalid;
    assign o_rsp.digital_out  = r_out_dig;
    assign o_rsp.value_out    = r_out_value;
    assign o_rsp.pwm_compare  = r_out_pwm;

endmodule

// ===== hdl/bgsf_checker.sv =====
module bgsf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bgsf_pkg::STATE_W-1:0]  i_run_state,
    input logic                          i_cli_enabled,
    input logic                          i_sample_valid,
    input logic                          i_digital_out,
    input logic [bgsf_pkg::VALUE_W-1:0]  i_value_out,
    input logic [bgsf_pkg::VALUE_W-1:0]  i_pwm_compare
);

    // stalled result stays put
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value_out)
            && $stable(i_run_state))
        else $error("stalled result changed");

    // a sample message only leaves in listening, with cli off
    a_msg_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sample_valid |-> (i_run_state == bgsf_pkg::ST_LISTEN) && !i_cli_enabled)
        else $error("sample message outside listening");

    // no message means empty payload
    a_msg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_sample_valid |->
            (i_value_out == '0) && (i_pwm_compare == '0) && !i_digital_out)
        else $error("payload without sample message");

    // pwm compare is always a shifted sample
    a_pwm_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pwm_compare[bgsf_pkg::PWM_SHIFT-1:0] == '0))
        else $error("pwm compare low bits set");

endmodule

bind button_gated_sample_filter_top bgsf_checker u_bgsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_run_state    (o_rsp.run_state),
    .i_cli_enabled  (o_rsp.cli_enabled),
    .i_sample_valid (o_rsp.sample_valid),
    .i_digital_out  (o_rsp.digital_out),
    .i_value_out    (o_rsp.value_out),
    .i_pwm_compare  (o_rsp.pwm_compare)
);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // mode code that the block treats as raw
    localparam logic [bgsf_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // cycles with no request moving on either side before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    // extra cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 3;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 116;

    typedef struct packed {
        logic [bgsf_pkg::STATE_W-1:0] run_state;
        logic                         cli_enabled;
        logic                         sample_valid;
        logic                         digital_out;
        logic [bgsf_pkg::VALUE_W-1:0] value_out;
        logic [bgsf_pkg::VALUE_W-1:0] pwm_compare;
    } t_filter_result;

    // predicts one result per accepted tick and checks the block against it
    class sample_filter_scoreboard;
        logic [bgsf_pkg::STATE_W-1:0]  run_state;
        logic [bgsf_pkg::MODE_W-1:0]   mode;
        logic [bgsf_pkg::VALUE_W-1:0]  or_mask;
        logic [bgsf_pkg::SAMPLE_W-1:0] sample_window [bgsf_pkg::WINDOW_LENGTH];
        t_filter_result                awaited_results [$];
        int                            mismatches;
        int                            unexpected;
        int                            ticks;
        int                            presses;
        int                            messages [4];

        function new();
            run_state  = bgsf_pkg::ST_INIT;
            mode       = bgsf_pkg::MODE_RAW;
            or_mask    = bgsf_pkg::MASK_RESET;
            mismatches = 0;
            unexpected = 0;
            ticks      = 0;
            presses    = 0;
            foreach (sample_window[i]) sample_window[i] = '0;
            foreach (messages[i]) messages[i] = 0;
        endfunction

        function void write_register(logic [bgsf_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bgsf_pkg::CFG_W-1:0] wdata);
            case (idx)
                bgsf_pkg::REG_MODE: mode = wdata[bgsf_pkg::MODE_W-1:0];
                bgsf_pkg::REG_MASK: or_mask = wdata[bgsf_pkg::VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic button_level, logic digital_level,
                                logic [bgsf_pkg::SAMPLE_W-1:0] sample);
            t_filter_result r;
            int unsigned    total;
            logic [31:0]    v;
            logic           pressed;
            int             i;
            pressed = !button_level;
            r = '0;
            ticks++;
            if (pressed) presses++;
            case (run_state)
                bgsf_pkg::ST_INIT: begin
                    mode      = bgsf_pkg::MODE_RAW;
                    run_state = bgsf_pkg::ST_WAIT;
                end
                bgsf_pkg::ST_LISTEN: begin
                    if (pressed) begin
                        run_state = bgsf_pkg::ST_PAUSE;
                    end else begin
                        r.sample_valid = 1'b1;
                        r.digital_out  = digital_level;
                        r.pwm_compare  = bgsf_pkg::VALUE_W'(sample);
                        r.pwm_compare  = r.pwm_compare << bgsf_pkg::PWM_SHIFT;
                        messages[mode]++;
                        if (mode == bgsf_pkg::MODE_AVG) begin
                            total = 32'(sample);
                            for (i = 0; i < bgsf_pkg::WINDOW_LENGTH - 1; i++) begin
                                sample_window[i] = sample_window[i + 1];
                                total += sample_window[i];
                            end
                            sample_window[bgsf_pkg::WINDOW_LENGTH - 1] = sample;
                            r.value_out = bgsf_pkg::VALUE_W'(total / bgsf_pkg::WINDOW_LENGTH);
                        end else if (mode == bgsf_pkg::MODE_NOISE) begin
                            v = 32'(sample);
                            v = v ^ (v << v[1:0]);
                            v = v + (v ^ (v >> 1));
                            if (v < bgsf_pkg::NOISE_THRESHOLD) v = v + (v | or_mask);
                            r.value_out = v[bgsf_pkg::VALUE_W-1:0];
                        end else begin
                            r.value_out = bgsf_pkg::VALUE_W'(sample);
                        end
                    end
                end
                default: begin
                    // waiting and paused behave alike
                    r.cli_enabled = 1'b1;
                    if (pressed) run_state = bgsf_pkg::ST_LISTEN;
                end
            endcase
            r.run_state = run_state;
            awaited_results.push_back(r);
        endfunction

        function void check_result(t_filter_result got);
            t_filter_result exp;
            if (awaited_results.size() == 0) begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("%0t: result with nothing awaited: state %0d value %h",
                             $realtime, got.run_state, got.value_out);
                return;
            end
            exp = awaited_results.pop_front();
            if (got.run_state !== exp.run_state || got.cli_enabled !== exp.cli_enabled ||
                got.sample_valid !== exp.sample_valid || got.digital_out !== exp.digital_out ||
                got.value_out !== exp.value_out || got.pwm_compare !== exp.pwm_compare) begin
                mismatches++;
                if (unexpected + mismatches <= 10) begin
                    $display("%0t: mismatch on tick result", $realtime);
                    $display("  exp state %0d cli %b valid %b dig %b value %h pwm %h",
                             exp.run_state, exp.cli_enabled, exp.sample_valid,
                             exp.digital_out, exp.value_out, exp.pwm_compare);
                    $display("  got state %0d cli %b valid %b dig %b value %h pwm %h",
                             got.run_state, got.cli_enabled, got.sample_valid,
                             got.digital_out, got.value_out, got.pwm_compare);
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bgsf_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [bgsf_pkg::CFG_W-1:0]     cfg_wdata;

    bgsf_in_if  req_if ();
    bgsf_out_if rsp_if ();

    sample_filter_scoreboard sb = new();

    // sender burst shaping and receiver stall pattern, changed per phase
    int          gap_max;
    int          burst_max;
    int          burst_left;
    logic [15:0] stall_pattern;
    int unsigned stall_pos;
    int          idle_cycles;

    button_gated_sample_filter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls follow a rotating pattern of its own
    always @(negedge clk) begin
        rsp_if.ready <= stall_pattern[stall_pos % 16];
        stall_pos++;
    end

    // monitor: results are checked before the request of the same edge is noted,
    // so an expectation always comes from an earlier edge
    always @(posedge clk) begin
        t_filter_result got;
        logic           progress;
        progress = 1'b0;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.run_state    = rsp_if.run_state;
                got.cli_enabled  = rsp_if.cli_enabled;
                got.sample_valid = rsp_if.sample_valid;
                got.digital_out  = rsp_if.digital_out;
                got.value_out    = rsp_if.value_out;
                got.pwm_compare  = rsp_if.pwm_compare;
                sb.check_result(got);
                progress = 1'b1;
            end
            if (req_if.valid && req_if.ready) begin
                sb.note_tick(req_if.button_level, req_if.digital_level, req_if.adc_sample);
                progress = 1'b1;
            end
        end
        // watchdog: nothing moving for too long means the block has hung
        if (progress) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one tick request; valid stays high into the next request of a burst
    task automatic send_request(input logic button_level, input logic digital_level,
                                input logic [bgsf_pkg::SAMPLE_W-1:0] sample);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = $urandom_range(0, gap_max);
            repeat (gap) begin
                @(negedge clk);
                req_if.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_if.valid         <= 1'b1;
        req_if.button_level  <= button_level;
        req_if.digital_level <= digital_level;
        req_if.adc_sample    <= sample;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // stop sending and let every awaited result drain out
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic [bgsf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bgsf_pkg::CFG_W-1:0] wdata);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= wdata;
        @(posedge clk);
        sb.write_register(idx, wdata);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [bgsf_pkg::MODE_W-1:0]   phase_mode;
        logic [bgsf_pkg::CFG_W-1:0]    cfg_value;
        logic [bgsf_pkg::SAMPLE_W-1:0] sample;
        int                            failures;
        // everything driven to a known value from time zero
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = bgsf_pkg::REG_MODE;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.button_level  = 1'b1;
        req_if.digital_level = 1'b0;
        req_if.adc_sample    = '0;
        rsp_if.ready         = 1'b0;
        stall_pattern        = 16'b1011_0111_1101_1110;
        stall_pos            = 0;
        gap_max              = 2;
        burst_max            = 4;
        burst_left           = 0;
        idle_cycles          = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a mode written before the init tick must be dropped by it
        write_register(bgsf_pkg::REG_MODE, {14'h0, bgsf_pkg::MODE_NOISE});

        send_request(1'b1, 1'b0, 12'h000);   // init tick
        send_request(1'b1, 1'b1, 12'hFFF);   // waiting, no press
        send_request(1'b0, 1'b1, 12'h123);   // press starts listening
        send_request(1'b1, 1'b1, 12'hFFF);   // raw, full scale
        send_request(1'b1, 1'b0, 12'h000);   // raw, zero
        send_request(1'b0, 1'b0, 12'h800);   // press while listening pauses, no message
        send_request(1'b1, 1'b1, 12'h555);   // paused, no press
        send_request(1'b0, 1'b0, 12'hAAA);   // press while paused resumes, cli still set
        settle();

        // window average: fill to full scale, then a single zero
        write_register(bgsf_pkg::REG_MODE, {14'h0, bgsf_pkg::MODE_AVG});
        repeat (9) send_request(1'b1, 1'b1, 12'hFFF);
        send_request(1'b1, 1'b0, 12'h000);
        settle();

        // noise scramble with an empty mask, small values fall under the threshold
        write_register(bgsf_pkg::REG_MODE, {14'h0, bgsf_pkg::MODE_NOISE});
        write_register(bgsf_pkg::REG_MASK, 16'h0000);
        send_request(1'b1, 1'b0, 12'h000);
        send_request(1'b1, 1'b1, 12'h001);
        send_request(1'b1, 1'b0, 12'h002);
        send_request(1'b1, 1'b1, 12'h003);
        send_request(1'b1, 1'b1, 12'hFFF);
        settle();

        // unused mode code with junk in the upper data bits passes the sample raw
        write_register(bgsf_pkg::REG_MODE, {14'h3FFF, MODE_UNUSED});
        send_request(1'b1, 1'b1, 12'hABC);

        // random phases: each starts from an idle block with fresh settings
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0, 5:    phase_mode = bgsf_pkg::MODE_AVG;
                1, 4:    phase_mode = bgsf_pkg::MODE_NOISE;
                2:       phase_mode = bgsf_pkg::MODE_RAW;
                3:       phase_mode = MODE_UNUSED;
                default: phase_mode = bgsf_pkg::MODE_W'($urandom_range(0, 3));
            endcase
            cfg_value = bgsf_pkg::CFG_W'($urandom);
            cfg_value[bgsf_pkg::MODE_W-1:0] = phase_mode;
            write_register(bgsf_pkg::REG_MODE, cfg_value);
            case (phase % 3)
                0:       cfg_value = 16'h0000;
                1:       cfg_value = bgsf_pkg::MASK_RESET;
                default: cfg_value = bgsf_pkg::CFG_W'($urandom);
            endcase
            write_register(bgsf_pkg::REG_MASK, cfg_value);

            // phases 2 and 5 never stall the receiver, phase 3 never starves the block
            if (phase == 2 || phase == 5) stall_pattern = '1;
            else stall_pattern = 16'($urandom) | 16'h0001;
            gap_max   = (phase == 3) ? 0 : $urandom_range(1, 8);
            burst_max = $urandom_range(1, 24);

            // mostly listening ticks, with the odd press toggling pause
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0)
                    sample = bgsf_pkg::SAMPLE_W'($urandom_range(0, 40));
                else
                    sample = bgsf_pkg::SAMPLE_W'($urandom_range(0, 4095));
                send_request($urandom_range(0, 11) != 0, 1'($urandom_range(0, 1)), sample);
            end
        end
        settle();

        failures = sb.mismatches + sb.unexpected + sb.awaited_results.size();
        $display("covered %0d ticks with %0d button presses over %0d setting phases",
                 sb.ticks, sb.presses, PHASE_COUNT + 4);
        $display("sample messages: raw %0d, averaged %0d, scrambled %0d, unused code %0d",
                 sb.messages[bgsf_pkg::MODE_RAW], sb.messages[bgsf_pkg::MODE_AVG],
                 sb.messages[bgsf_pkg::MODE_NOISE], sb.messages[MODE_UNUSED]);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d unexpected results", sb.mismatches, sb.unexpected);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bgsf_pkg.sv
hdl/bgsf_in_if.sv
hdl/bgsf_out_if.sv
hdl/bgsf_cell.sv
hdl/bgsf_window.sv
hdl/button_gated_sample_filter_top.sv
hdl/bgsf_checker.sv
verif/testbench.sv
